// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SCU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scu_pkg.sv =====
package scu_pkg;

    localparam int START_W = 32;
    localparam int LEN_W   = 16;
    localparam int SPAN_W  = 33;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_REWIND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SPAN_W-1:0]  length;
    } entry_t;

endpackage

// ===== rtl/scu_ram.sv =====
module scu_ram #(
    parameter int ADDR_W = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  scu_pkg::entry_t     wdata,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output scu_pkg::entry_t     rd_data
);

    scu_pkg::entry_t mem [2**ADDR_W];
    scu_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stream_interval_coalescer_unit.sv =====
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start / busy         | action, range_start, range_length
// result    | result_valid strobe  | interval_start, interval_length,
//           |                      | final_interval, list_empty, overflow,
//           |                      | stream_length
//
// a push holds busy until its list is done and lists merged ranges as they
// close; with a full list it lists nothing while merging, and the list is read
// back from the ram after the merge
// the single ram read port gives at most one entry a cycle
// a clear never raises busy
// reset empties the list; the receiver cannot stall, results go out as made
module stream_interval_coalescer_unit #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] range_start,
    input  logic [15:0] range_length,
    output logic        result_valid,
    output logic [31:0] interval_start,
    output logic [32:0] interval_length,
    output logic        final_interval,
    output logic        list_empty,
    output logic        overflow,
    output logic [32:0] stream_length
);

    localparam int IDX_W  = $clog2(MAX_INTERVALS);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

    scu_pkg::state_t state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [32:0]      hw_reg, hw_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] tn_reg, tn_next;
    logic             placed_reg, placed_next;
    logic             full_reg, full_next;
    logic             ovf_reg, ovf_next;
    logic             acc_valid_reg, acc_valid_next;
    logic             res_valid_reg, res_valid_next;

    logic [31:0]      ns_reg, ns_next;
    logic [32:0]      ne_reg, ne_next;
    logic [31:0]      acc_s_reg, acc_s_next;
    logic [32:0]      acc_e_reg, acc_e_next;
    logic [31:0]      res_start_reg, res_start_next;
    logic [32:0]      res_len_reg, res_len_next;
    logic             res_final_reg, res_final_next;
    logic             res_empty_reg, res_empty_next;
    logic             res_ovf_reg, res_ovf_next;
    logic [32:0]      res_sl_reg, res_sl_next;

    logic             we;
    logic [ADDR_W-1:0] waddr;
    scu_pkg::entry_t  wdata;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    scu_pkg::entry_t  rd_data;

    logic [32:0]      new_end;
    logic [32:0]      rd_end;
    logic             take_new;
    logic             at_end;
    logic [31:0]      cand_s;
    logic [32:0]      cand_e;
    logic             joins;
    logic [32:0]      acc_len;
    logic             tn_full;
    logic             fin_ovf;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] tn_inc;

    scu_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign new_end  = {1'b0, range_start} + {17'd0, range_length};
    assign rd_end   = {1'b0, rd_data.start} + rd_data.length;
    assign take_new = !placed_reg && ((idx_reg == count_reg) || (ns_reg <= rd_data.start));
    assign at_end   = placed_reg && (idx_reg == count_reg);
    assign cand_s   = take_new ? ns_reg : rd_data.start;
    assign cand_e   = take_new ? ne_reg : rd_end;
    assign joins    = acc_valid_reg && (acc_e_reg >= {1'b0, cand_s});
    assign acc_len  = acc_e_reg - {1'b0, acc_s_reg};
    assign tn_full  = (tn_reg == MAX_CNT);
    assign fin_ovf  = ovf_reg || tn_full;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign tn_inc   = tn_reg + CNT_W'(1);
    assign busy     = (state_reg != scu_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        hw_next        = hw_reg;
        idx_next       = idx_reg;
        tn_next        = tn_reg;
        placed_next    = placed_reg;
        full_next      = full_reg;
        ovf_next       = ovf_reg;
        acc_valid_next = acc_valid_reg;
        ns_next        = ns_reg;
        ne_next        = ne_reg;
        acc_s_next     = acc_s_reg;
        acc_e_next     = acc_e_reg;
        res_valid_next = 1'b0;
        res_start_next = res_start_reg;
        res_len_next   = res_len_reg;
        res_final_next = res_final_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;
        res_sl_next    = res_sl_reg;
        we             = 1'b0;
        waddr          = {~bank_reg, tn_reg[IDX_W-1:0]};
        wdata.start    = acc_s_reg;
        wdata.length   = acc_len;
        rd_en          = 1'b0;
        rd_addr        = {bank_reg, IDX_W'(0)};

        case (state_reg)
            scu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (action == scu_pkg::ACT_CLEAR)
                    begin
                        count_next     = '0;
                        hw_next        = '0;
                        res_valid_next = 1'b1;
                        res_start_next = '0;
                        res_len_next   = '0;
                        res_final_next = 1'b1;
                        res_empty_next = 1'b1;
                        res_ovf_next   = 1'b0;
                        res_sl_next    = '0;
                    end
                    else
                    begin
                        ns_next        = range_start;
                        ne_next        = new_end;
                        if (new_end > hw_reg)
                        begin
                            hw_next = new_end;
                        end
                        idx_next       = '0;
                        tn_next        = '0;
                        placed_next    = 1'b0;
                        acc_valid_next = 1'b0;
                        ovf_next       = 1'b0;
                        full_next      = (count_reg == MAX_CNT);
                        rd_en          = (count_reg != '0);
                        state_next     = scu_pkg::ST_MERGE;
                    end
                end
            end

            scu_pkg::ST_MERGE:
            begin
                if (at_end)
                begin
                    we = !fin_ovf;
                    if (!full_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_start_next = acc_s_reg;
                        res_len_next   = acc_len;
                        res_final_next = 1'b1;
                        res_empty_next = 1'b0;
                        res_ovf_next   = 1'b0;
                        res_sl_next    = hw_reg;
                        bank_next      = ~bank_reg;
                        count_next     = tn_inc;
                        state_next     = scu_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ovf_next = fin_ovf;
                        if (!fin_ovf)
                        begin
                            bank_next  = ~bank_reg;
                            count_next = tn_inc;
                        end
                        state_next = scu_pkg::ST_REWIND;
                    end
                end
                else
                begin
                    if (take_new)
                    begin
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        if (idx_inc < count_reg)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = {bank_reg, idx_inc[IDX_W-1:0]};
                        end
                    end
                    if (joins)
                    begin
                        if (cand_e > acc_e_reg)
                        begin
                            acc_e_next = cand_e;
                        end
                    end
                    else
                    begin
                        if (acc_valid_reg)
                        begin
                            if (tn_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                we      = 1'b1;
                                tn_next = tn_inc;
                                if (!full_reg)
                                begin
                                    res_valid_next = 1'b1;
                                    res_start_next = acc_s_reg;
                                    res_len_next   = acc_len;
                                    res_final_next = 1'b0;
                                    res_empty_next = 1'b0;
                                    res_ovf_next   = 1'b0;
                                    res_sl_next    = hw_reg;
                                end
                            end
                        end
                        acc_valid_next = 1'b1;
                        acc_s_next     = cand_s;
                        acc_e_next     = cand_e;
                    end
                end
            end

            scu_pkg::ST_REWIND:
            begin
                rd_en      = 1'b1;
                idx_next   = '0;
                state_next = scu_pkg::ST_EMIT;
            end

            scu_pkg::ST_EMIT:
            begin
                res_valid_next = 1'b1;
                res_start_next = rd_data.start;
                res_len_next   = rd_data.length;
                res_final_next = (idx_inc == count_reg);
                res_empty_next = 1'b0;
                res_ovf_next   = ovf_reg;
                res_sl_next    = hw_reg;
                idx_next       = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = scu_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = {bank_reg, idx_inc[IDX_W-1:0]};
                end
            end

            default:
            begin
                state_next = scu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scu_pkg::ST_IDLE;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            hw_reg        <= '0;
            idx_reg       <= '0;
            tn_reg        <= '0;
            placed_reg    <= 1'b0;
            full_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            acc_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            idx_reg       <= idx_next;
            tn_reg        <= tn_next;
            placed_reg    <= placed_next;
            full_reg      <= full_next;
            ovf_reg       <= ovf_next;
            acc_valid_reg <= acc_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg        <= ns_next;
        ne_reg        <= ne_next;
        acc_s_reg     <= acc_s_next;
        acc_e_reg     <= acc_e_next;
        res_start_reg <= res_start_next;
        res_len_reg   <= res_len_next;
        res_final_reg <= res_final_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
        res_sl_reg    <= res_sl_next;
    end

    assign result_valid    = res_valid_reg;
    assign interval_start  = res_start_reg;
    assign interval_length = res_len_reg;
    assign final_interval  = res_final_reg;
    assign list_empty      = res_empty_reg;
    assign overflow        = res_ovf_reg;
    assign stream_length   = res_sl_reg;

endmodule

// ===== rtl/scu_checker.sv =====
`include "assert_macros.svh"

module scu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        result_valid,
    input logic [32:0] interval_length,
    input logic        final_interval,
    input logic        list_empty,
    input logic        overflow,
    input logic [32:0] stream_length
);

    logic push_req;
    logic clear_req;
    logic marker_out;
    logic marker_ok;
    logic more_out;

    assign push_req   = start && !busy && (action == scu_pkg::ACT_PUSH);
    assign clear_req  = start && !busy && (action == scu_pkg::ACT_CLEAR);
    assign marker_out = result_valid && list_empty;
    assign marker_ok  = final_interval && !overflow && (interval_length == 33'd0)
                        && (stream_length == 33'd0);
    assign more_out   = result_valid && !final_interval;

    `SCU_ASSERT_NEXT(a_clear_marker, clear_req, marker_out, "clear gave no marker")
    `SCU_ASSERT_NOW(a_marker_shape, marker_out, marker_ok, "bad empty marker")
    `SCU_ASSERT_NEXT(a_push_busy, push_req, busy, "push did not raise busy")
    `SCU_ASSERT_NOW(a_more_pending, more_out, busy && !list_empty, "listing ended early")

endmodule

bind stream_interval_coalescer_unit scu_checker u_scu_checker (.*);
